// ----- rtl/g2enu_pkg.sv -----
// Shared types and constants for the geodetic to local east/north converter.
package g2enu_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 33;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_LAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_LON = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEMI_MAJOR = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEMI_MINOR = 2'd3;

   localparam logic [30:0] ORIGIN_LAT_RESET = 31'd375403580;
   localparam logic [31:0] ORIGIN_LON_RESET = 32'd1270748800;
   localparam logic [32:0] SEMI_MAJOR_RESET = 33'd6378137000;
   localparam logic [32:0] SEMI_MINOR_RESET = 33'd6356752314;

   // 1e-7 degree and 1e-5 degree to Q4.28 radian scale factors
   localparam logic [30:0] DEG7_TO_Q28 = 31'd2012227627;
   localparam logic [29:0] DEG5_TO_Q28 = 30'd786026417;
   localparam logic signed [35:0] TWO_PI_Q28 = 36'sd1686629713;
   localparam logic [30:0] RATIO_MAX = 31'd1342177280;

   localparam int WORK_FIFO_DEPTH = 4;
   localparam int RSP_FIFO_DEPTH  = 2;

   typedef struct packed {
      logic signed [30:0] lat_q;
      logic signed [31:0] dlon;
      logic signed [31:0] dlat;
      logic [30:0]        head_q;
   } work_type;

   typedef struct packed {
      logic signed [31:0] east_mm;
      logic signed [31:0] north_mm;
      logic               saturated;
      logic [30:0]        heading_angle;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
   } rsp_type;

endpackage

// ----- rtl/g2enu_fifo.sv -----
// Small register FIFO used between the front end, the back end and the result port.
module g2enu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/g2enu_front.sv -----
// Front end: accepts fixes, converts angles to Q4.28 radians, forms origin deltas, wraps heading.
module g2enu_front import g2enu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_lon_raw,
   input  logic signed [30:0] req_lat_raw,
   input  logic signed [27:0] req_heading_raw,
   input  logic [30:0]        origin_lat,
   input  logic [31:0]        origin_lon,
   output logic               work_push,
   input  logic               work_full,
   output work_type           work_data
);

   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic s2_load_ok, s1_move, accept;

   logic [31:0] lon_mag, olon_mag;
   logic [30:0] lat_mag, olat_mag;
   logic [27:0] head_mag;

   logic [62:0] lon_prod_ff, olon_prod_ff;
   logic [61:0] lat_prod_ff, olat_prod_ff;
   logic [57:0] head_prod_ff;
   logic        lon_neg_ff, olon_neg_ff, lat_neg_ff, olat_neg_ff, head_neg_ff;

   logic [63:0] lon_sum, olon_sum;
   logic [62:0] lat_sum, olat_sum;
   logic [58:0] head_sum;
   logic signed [31:0] lon_q, olon_q;
   logic signed [30:0] lat_q, olat_q;
   logic signed [35:0] h0, h1, h2, h3;

   work_type s2_data_ff, s2_data_in;

   assign s2_load_ok = ~s2_v_ff | ~work_full;
   assign s1_move    = s1_v_ff & s2_load_ok;
   assign req_full   = s1_v_ff & ~s2_load_ok;
   assign accept     = req_push & ~req_full;
   assign work_push  = s2_v_ff;
   assign work_data  = s2_data_ff;

   always_comb begin
      s1_v_in = s1_v_ff;
      s2_v_in = s2_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end
      if (s1_move) begin
         s2_v_in = 1'b1;
      end else if (s2_v_ff && !work_full) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // stage 1: magnitudes times the degree to radian scale
   assign lon_mag  = req_lon_raw[31] ? 32'(-req_lon_raw) : 32'(req_lon_raw);
   assign lat_mag  = req_lat_raw[30] ? 31'(-req_lat_raw) : 31'(req_lat_raw);
   assign head_mag = req_heading_raw[27] ? 28'(-req_heading_raw) : 28'(req_heading_raw);
   assign olon_mag = origin_lon[31] ? (~origin_lon + 32'd1) : origin_lon;
   assign olat_mag = origin_lat[30] ? (~origin_lat + 31'd1) : origin_lat;

   always_ff @(posedge clock) begin
      if (accept) begin
         lon_prod_ff  <= 63'(lon_mag) * 63'(DEG7_TO_Q28);
         olon_prod_ff <= 63'(olon_mag) * 63'(DEG7_TO_Q28);
         lat_prod_ff  <= 62'(lat_mag) * 62'(DEG7_TO_Q28);
         olat_prod_ff <= 62'(olat_mag) * 62'(DEG7_TO_Q28);
         head_prod_ff <= 58'(head_mag) * 58'(DEG5_TO_Q28);
         lon_neg_ff   <= req_lon_raw[31];
         olon_neg_ff  <= origin_lon[31];
         lat_neg_ff   <= req_lat_raw[30];
         olat_neg_ff  <= origin_lat[30];
         head_neg_ff  <= req_heading_raw[27];
      end
   end

   // stage 2: round half away from zero, restore sign, subtract origin, wrap heading
   always_comb begin
      lon_sum  = {1'b0, lon_prod_ff} + (64'd1 << 31);
      olon_sum = {1'b0, olon_prod_ff} + (64'd1 << 31);
      lat_sum  = {1'b0, lat_prod_ff} + (63'd1 << 31);
      olat_sum = {1'b0, olat_prod_ff} + (63'd1 << 31);
      head_sum = {1'b0, head_prod_ff} + (59'd1 << 23);

      lon_q  = lon_neg_ff ? -$signed(lon_sum[63:32]) : $signed(lon_sum[63:32]);
      olon_q = olon_neg_ff ? -$signed(olon_sum[63:32]) : $signed(olon_sum[63:32]);
      lat_q  = lat_neg_ff ? -$signed(lat_sum[62:32]) : $signed(lat_sum[62:32]);
      olat_q = olat_neg_ff ? -$signed(olat_sum[62:32]) : $signed(olat_sum[62:32]);

      h0 = head_neg_ff ? -$signed({1'b0, head_sum[58:24]}) : $signed({1'b0, head_sum[58:24]});
      h1 = (h0 < 0) ? h0 + TWO_PI_Q28 : h0;
      h2 = (h1 > TWO_PI_Q28) ? h1 - TWO_PI_Q28 : h1;
      if (h2 < 0) begin
         h3 = '0;
      end else if (h2 > TWO_PI_Q28) begin
         h3 = TWO_PI_Q28;
      end else begin
         h3 = h2;
      end

      s2_data_in.lat_q  = lat_q;
      s2_data_in.dlon   = lon_q - olon_q;
      s2_data_in.dlat   = 32'(lat_q) - 32'(olat_q);
      s2_data_in.head_q = h3[30:0];
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_data_ff <= s2_data_in;
      end
   end

endmodule

// ----- rtl/g2enu_back.sv -----
// Back end: CORDIC sin/cos, radius of curvature via square root and divide, offsets.
module g2enu_back import g2enu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        work_empty,
   output logic        work_pop,
   input  work_type    work_data,
   input  logic [32:0] semi_major_mm,
   input  logic [32:0] semi_minor_mm,
   output logic        rsp_push,
   input  logic        rsp_full,
   output rsp_type     rsp_data
);

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
   } root_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] quo;
   } div_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } offs_type;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
   localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ROT    = 4'd1;
   localparam logic [3:0] ST_CLAMP  = 4'd2;
   localparam logic [3:0] ST_SCALE  = 4'd3;
   localparam logic [3:0] ST_SQUARE = 4'd4;
   localparam logic [3:0] ST_SUM    = 4'd5;
   localparam logic [3:0] ST_ROOT   = 4'd6;
   localparam logic [3:0] ST_DIVSET = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_FIX    = 4'd9;
   localparam logic [3:0] ST_NRAD   = 4'd10;
   localparam logic [3:0] ST_PROD   = 4'd11;
   localparam logic [3:0] ST_MRAD   = 4'd12;
   localparam logic [3:0] ST_OFFS   = 4'd13;
   localparam logic [3:0] ST_DONE   = 4'd14;

   localparam logic [3:0] ROT_LAST  = 4'd14;
   localparam logic [3:0] LOOP_LAST = 4'd15;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
      case (idx)
         5'd0:    return 36'sh03243F6A8;
         5'd1:    return 36'sh01DAC6705;
         5'd2:    return 36'sh00FADBAFC;
         5'd3:    return 36'sh007F56EA6;
         5'd4:    return 36'sh003FEAB76;
         5'd5:    return 36'sh001FFD55B;
         5'd6:    return 36'sh000FFFAAA;
         5'd7:    return 36'sh0007FFF55;
         5'd8:    return 36'sh0003FFFEA;
         5'd9:    return 36'sh0001FFFFD;
         5'd10:   return 36'sh0000FFFFF;
         5'd11:   return 36'sh00007FFFF;
         5'd12:   return 36'sh00003FFFF;
         5'd13:   return 36'sh00001FFFF;
         5'd14:   return 36'sh00000FFFF;
         5'd15:   return 36'sh000007FFF;
         5'd16:   return 36'sh000003FFF;
         5'd17:   return 36'sh000001FFF;
         5'd18:   return 36'sh000000FFF;
         5'd19:   return 36'sh0000007FF;
         5'd20:   return 36'sh0000003FF;
         5'd21:   return 36'sh0000001FF;
         5'd22:   return 36'sh0000000FF;
         5'd23:   return 36'sh00000007F;
         5'd24:   return 36'sh00000003F;
         5'd25:   return 36'sh00000001F;
         5'd26:   return 36'sh00000000F;
         5'd27:   return 36'sh000000008;
         5'd28:   return 36'sh000000004;
         5'd29:   return 36'sh000000002;
         default: return 36'sh000000000;
      endcase
   endfunction

   // reflect angles beyond a quarter turn through +-pi
   function automatic cordic_type cordic_start(input logic signed [35:0] ang);
      cordic_type st;
      st.x    = GAIN_Q30;
      st.y    = '0;
      st.z    = ang;
      st.flip = 1'b0;
      if (ang > HALF_PI_Q30) begin
         st.z    = PI_Q30 - ang;
         st.flip = 1'b1;
      end else if (ang < -HALF_PI_Q30) begin
         st.z    = -PI_Q30 - ang;
         st.flip = 1'b1;
      end
      return st;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type cur, input logic [4:0] idx);
      cordic_type         nxt;
      logic signed [35:0] dx, dy, ang;
      dx       = cur.y >>> idx;
      dy       = cur.x >>> idx;
      ang      = atan_q30(idx);
      nxt.flip = cur.flip;
      if (!cur.z[35]) begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - ang;
      end else begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + ang;
      end
      return nxt;
   endfunction

   function automatic logic signed [31:0] clamp_unit(input logic signed [35:0] v);
      if (v > ONE_Q30) begin
         return 32'(ONE_Q30);
      end else if (v < -ONE_Q30) begin
         return 32'(-ONE_Q30);
      end
      return v[31:0];
   endfunction

   function automatic root_type root_step(input root_type cur, input logic [1:0] pair);
      root_type    nxt;
      logic [35:0] r2, trial;
      r2    = {cur.rem[33:0], pair};
      trial = {2'b00, cur.root, 2'b01};
      if (r2 >= trial) begin
         nxt.rem  = r2 - trial;
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem  = r2;
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic div_type div_step(input div_type cur, input logic nbit,
                                        input logic [31:0] divisor);
      div_type     nxt;
      logic [33:0] r2;
      r2 = {cur.rem[32:0], nbit};
      if (r2 >= {2'b00, divisor}) begin
         nxt.rem = r2 - {2'b00, divisor};
         nxt.quo = {cur.quo[30:0], 1'b1};
      end else begin
         nxt.rem = r2;
         nxt.quo = {cur.quo[30:0], 1'b0};
      end
      return nxt;
   endfunction

   // round half away from zero at 2^25, restore sign, clip to 32 bits
   function automatic offs_type offset_round(input logic [64:0] prod, input logic neg);
      offs_type    res;
      logic [65:0] sum;
      logic [40:0] p;
      sum     = {1'b0, prod} + (66'd1 << 24);
      p       = sum[65:25];
      res.sat = 1'b0;
      if (neg) begin
         if (p > 41'd2147483648) begin
            res.sat = 1'b1;
            res.val = 32'sh80000000;
         end else begin
            res.val = -$signed(p[31:0]);
         end
      end else begin
         if (p > 41'd2147483647) begin
            res.sat = 1'b1;
            res.val = 32'sh7FFFFFFF;
         end else begin
            res.val = $signed(p[31:0]);
         end
      end
      return res;
   endfunction

   logic [3:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   cordic_type lat_c_ff, head_c_ff, lat_s1, lat_s2, head_s1, head_s2;
   logic signed [31:0] dlon_ff, dlat_ff;
   logic [30:0]        head_ff;

   logic signed [31:0] cval, sval, cabs, sabs;
   logic [30:0]        cmag_ff, smag_ff;
   logic               cneg_ff;
   logic signed [31:0] qz_ff, qw_ff;

   logic [31:0] ac_ff, bs_ff;
   logic [63:0] sqa_ff, sqb_ff, src_ff;
   logic [63:0] ac_prod, bs_prod;
   root_type    root_ff, rs1, rs2;

   logic [30:0] anum, bnum;
   div_type     tdiv_ff, udiv_ff, td1, td2, ud1, ud2;
   logic        tclamp_ff, uclamp_ff;
   logic        ta_hi, ta_lo, ub_hi, ub_lo;

   logic [30:0] t_ff, u_ff;
   logic [33:0] n_ff;
   logic [34:0] nc_ff, nu_ff;
   logic [35:0] m_ff;
   logic [63:0] a_t_prod;
   logic [64:0] n_c_prod, n_u_prod;
   logic [65:0] m_prod;
   logic [31:0] dlon_mag, dlat_mag;
   logic [64:0] eprod_ff, nprod_ff;
   offs_type    east_ff, east_res, north_res;

   assign work_pop = (state_ff == ST_IDLE) & ~work_empty;
   assign rsp_push = (state_ff == ST_DONE);

   assign anum = semi_major_mm[32:2];
   assign bnum = semi_minor_mm[32:2];

   always_comb begin
      lat_s1  = cordic_step(lat_c_ff, {cnt_ff, 1'b0});
      lat_s2  = cordic_step(lat_s1, {cnt_ff, 1'b1});
      head_s1 = cordic_step(head_c_ff, {cnt_ff, 1'b0});
      head_s2 = cordic_step(head_s1, {cnt_ff, 1'b1});

      cval = clamp_unit(lat_c_ff.flip ? -lat_c_ff.x : lat_c_ff.x);
      sval = clamp_unit(lat_c_ff.y);
      cabs = cval[31] ? -cval : cval;
      sabs = sval[31] ? -sval : sval;

      ac_prod = 64'(semi_major_mm) * 64'(cmag_ff);
      bs_prod = 64'(semi_minor_mm) * 64'(smag_ff);

      rs1 = root_step(root_ff, src_ff[63:62]);
      rs2 = root_step(rs1, src_ff[61:60]);

      // the numerator carries its two low bits into the first step only
      ta_hi = (cnt_ff == '0) ? anum[1] : 1'b0;
      ta_lo = (cnt_ff == '0) ? anum[0] : 1'b0;
      ub_hi = (cnt_ff == '0) ? bnum[1] : 1'b0;
      ub_lo = (cnt_ff == '0) ? bnum[0] : 1'b0;
      td1 = div_step(tdiv_ff, ta_hi, root_ff.root);
      td2 = div_step(td1, ta_lo, root_ff.root);
      ud1 = div_step(udiv_ff, ub_hi, root_ff.root);
      ud2 = div_step(ud1, ub_lo, root_ff.root);

      a_t_prod = 64'(semi_major_mm) * 64'(t_ff);
      n_c_prod = 65'(n_ff) * 65'(cmag_ff);
      n_u_prod = 65'(n_ff) * 65'(u_ff);
      m_prod   = 66'(nu_ff) * 66'(u_ff);

      dlon_mag = dlon_ff[31] ? 32'(-dlon_ff) : 32'(dlon_ff);
      dlat_mag = dlat_ff[31] ? 32'(-dlat_ff) : 32'(dlat_ff);

      east_res  = offset_round(eprod_ff, dlon_ff[31] ^ cneg_ff);
      north_res = offset_round(nprod_ff, dlat_ff[31]);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!work_empty) begin
               state_in = ST_ROT;
               cnt_in   = '0;
            end
         end
         ST_ROT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROT_LAST) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_ROOT;
            cnt_in   = '0;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LOOP_LAST) begin
               state_in = ST_DIVSET;
            end
         end
         ST_DIVSET: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LOOP_LAST) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:  state_in = ST_NRAD;
         ST_NRAD: state_in = ST_PROD;
         ST_PROD: state_in = ST_MRAD;
         ST_MRAD: state_in = ST_OFFS;
         ST_OFFS: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (!work_empty) begin
               lat_c_ff  <= cordic_start(36'(work_data.lat_q) <<< 2);
               head_c_ff <= cordic_start($signed({4'b0000, work_data.head_q, 1'b0}));
               dlon_ff   <= work_data.dlon;
               dlat_ff   <= work_data.dlat;
               head_ff   <= work_data.head_q;
            end
         end
         ST_ROT: begin
            lat_c_ff  <= lat_s2;
            head_c_ff <= head_s2;
         end
         ST_CLAMP: begin
            cmag_ff <= cabs[30:0];
            smag_ff <= sabs[30:0];
            cneg_ff <= cval[31];
            qz_ff   <= clamp_unit(head_c_ff.y);
            qw_ff   <= clamp_unit(head_c_ff.flip ? -head_c_ff.x : head_c_ff.x);
         end
         ST_SCALE: begin
            ac_ff <= ac_prod[63:32];
            bs_ff <= bs_prod[63:32];
         end
         ST_SQUARE: begin
            sqa_ff <= 64'(ac_ff) * 64'(ac_ff);
            sqb_ff <= 64'(bs_ff) * 64'(bs_ff);
         end
         ST_SUM: begin
            src_ff  <= sqa_ff + sqb_ff;
            root_ff <= '0;
         end
         ST_ROOT: begin
            root_ff <= rs2;
            src_ff  <= {src_ff[59:0], 4'b0000};
         end
         ST_DIVSET: begin
            tclamp_ff   <= (root_ff.root == '0) ||
                           ({2'b00, anum} >= {root_ff.root, 1'b0});
            uclamp_ff   <= (root_ff.root == '0) ||
                           ({2'b00, bnum} >= {root_ff.root, 1'b0});
            tdiv_ff.rem <= 34'(anum[30:2]);
            tdiv_ff.quo <= '0;
            udiv_ff.rem <= 34'(bnum[30:2]);
            udiv_ff.quo <= '0;
         end
         ST_DIV: begin
            tdiv_ff <= td2;
            udiv_ff <= ud2;
         end
         ST_FIX: begin
            t_ff <= (tclamp_ff || tdiv_ff.quo > 32'(RATIO_MAX)) ? RATIO_MAX : tdiv_ff.quo[30:0];
            u_ff <= (uclamp_ff || udiv_ff.quo > 32'(RATIO_MAX)) ? RATIO_MAX : udiv_ff.quo[30:0];
         end
         ST_NRAD: begin
            n_ff <= a_t_prod[63:30];
         end
         ST_PROD: begin
            nc_ff <= n_c_prod[64:30];
            nu_ff <= n_u_prod[64:30];
         end
         ST_MRAD: begin
            m_ff     <= m_prod[65:30];
            eprod_ff <= 65'(dlon_mag) * 65'(nc_ff[34:3]);
         end
         ST_OFFS: begin
            nprod_ff <= 65'(dlat_mag) * 65'(m_ff[35:3]);
            east_ff  <= east_res;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data.east_mm       = east_ff.val;
      rsp_data.north_mm      = north_res.val;
      rsp_data.saturated     = east_ff.sat | north_res.sat;
      rsp_data.heading_angle = head_ff;
      rsp_data.quat_z        = qz_ff;
      rsp_data.quat_w        = qw_ff;
   end

endmodule

// ----- rtl/geodetic_to_local_enu.sv -----
// Top level: configuration registers, front end, work queue, back end and result queue.
//
// Converts one GNSS fix per transaction into east/north millimetre offsets from the
// configured origin, plus the wrapped heading and its yaw quaternion. The input side
// takes a transaction in any cycle that full is low: a two-stage front end feeds a
// four-entry work queue, so a short burst is absorbed at one per cycle. The back end
// processes one fix at a time under its single sequencer: paired CORDIC rotations
// (latitude and heading side by side), a two-bit-per-cycle square root, the paired
// two-bit-per-cycle dividers, and a chain of multiplies. Write the configuration
// registers only while no fix is in flight.
module geodetic_to_local_enu import g2enu_pkg::*; #(
   parameter int WORK_DEPTH = WORK_FIFO_DEPTH,
   parameter int RSP_DEPTH  = RSP_FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic signed [31:0]     req_lon_raw,
   input  logic signed [30:0]     req_lat_raw,
   input  logic signed [27:0]     req_heading_raw,
   output logic                   empty,
   input  logic                   pop,
   output logic signed [31:0]     rsp_east_mm,
   output logic signed [31:0]     rsp_north_mm,
   output logic                   rsp_saturated,
   output logic [30:0]            rsp_heading_angle,
   output logic signed [31:0]     rsp_quat_z,
   output logic signed [31:0]     rsp_quat_w,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [30:0] origin_lat_ff;
   logic [31:0] origin_lon_ff;
   logic [32:0] semi_major_ff, semi_minor_ff;

   logic     work_push, work_full, work_pop, work_empty;
   work_type work_in, work_out;
   logic     rsp_push, rsp_full;
   rsp_type  rsp_in, rsp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff <= ORIGIN_LAT_RESET;
         origin_lon_ff <= ORIGIN_LON_RESET;
         semi_major_ff <= SEMI_MAJOR_RESET;
         semi_minor_ff <= SEMI_MINOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_LAT: origin_lat_ff <= csr_wdata[30:0];
            CSR_ORIGIN_LON: origin_lon_ff <= csr_wdata[31:0];
            CSR_SEMI_MAJOR: semi_major_ff <= csr_wdata;
            CSR_SEMI_MINOR: semi_minor_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   g2enu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_full        (full),
      .req_lon_raw     (req_lon_raw),
      .req_lat_raw     (req_lat_raw),
      .req_heading_raw (req_heading_raw),
      .origin_lat      (origin_lat_ff),
      .origin_lon      (origin_lon_ff),
      .work_push       (work_push),
      .work_full       (work_full),
      .work_data       (work_in)
   );

   g2enu_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (WORK_DEPTH)
   ) u_work_fifo (
      .clock (clock),
      .reset (reset),
      .push  (work_push),
      .full  (work_full),
      .wdata (work_in),
      .pop   (work_pop),
      .empty (work_empty),
      .rdata (work_out)
   );

   g2enu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .work_empty    (work_empty),
      .work_pop      (work_pop),
      .work_data     (work_out),
      .semi_major_mm (semi_major_ff),
      .semi_minor_mm (semi_minor_ff),
      .rsp_push      (rsp_push),
      .rsp_full      (rsp_full),
      .rsp_data      (rsp_in)
   );

   g2enu_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_in),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_out)
   );

   assign rsp_east_mm       = rsp_out.east_mm;
   assign rsp_north_mm      = rsp_out.north_mm;
   assign rsp_saturated     = rsp_out.saturated;
   assign rsp_heading_angle = rsp_out.heading_angle;
   assign rsp_quat_z        = rsp_out.quat_z;
   assign rsp_quat_w        = rsp_out.quat_w;

endmodule

// ----- bench/enu_checker.sv -----
// Predicts east/north, heading and yaw quaternion per fix and checks every result.
module enu_checker import g2enu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic signed [31:0]     req_lon_raw,
   input  logic signed [30:0]     req_lat_raw,
   input  logic signed [27:0]     req_heading_raw,
   input  logic                   empty,
   input  logic                   pop,
   input  logic signed [31:0]     rsp_east_mm,
   input  logic signed [31:0]     rsp_north_mm,
   input  logic                   rsp_saturated,
   input  logic [30:0]            rsp_heading_angle,
   input  logic signed [31:0]     rsp_quat_z,
   input  logic signed [31:0]     rsp_quat_w,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_fixes,
   output int                     checked_fixes,
   output int                     sat_fixes
);

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HEAD_WRAP   = 64'sd1686629713;

   longint atan_tbl [30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

   logic signed [30:0] org_lat;
   logic signed [31:0] org_lon;
   logic [32:0]        axis_a, axis_b;
   rsp_type            fix_results [$];
   int                 mism;

   function automatic longint mag64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint to_rad(longint v, longint c, int sh);
      longint p;
      p = (mag64(v) * c + (64'sd1 << (sh - 1))) >>> sh;
      return v < 0 ? -p : p;
   endfunction

   function automatic longint clamp_one(longint v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
   endfunction

   task automatic rotate(input longint ang, output longint sn, output longint cs);
      bit flip;
      longint x, y, z, nx;
      flip = 0;
      x = 652032874;
      y = 0;
      if (ang > HALF_PI_Q30) begin
         ang = PI_Q30 - ang; flip = 1;
      end else if (ang < -HALF_PI_Q30) begin
         ang = -PI_Q30 - ang; flip = 1;
      end
      z = ang;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tbl[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_tbl[i];
         end
         x = nx;
      end
      sn = clamp_one(y);
      cs = clamp_one(flip ? -x : x);
   endtask

   function automatic longint int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] axis_ratio(logic [63:0] num, logic [63:0] r);
      logic [63:0] q;
      if (r == 0) return RATIO_MAX;
      q = (num << 30) / r;
      return q > RATIO_MAX ? RATIO_MAX : q;
   endfunction

   function automatic longint offset(longint ang, longint rad, inout bit sat);
      logic [63:0] p;
      p = (mag64(ang) * (mag64(rad) >> 3) + (64'd1 << 24)) >> 25;
      if ((ang < 0) != (rad < 0)) begin
         if (p > 64'd2147483648) begin
            sat = 1; return -64'sd2147483648;
         end
         return -longint'(p);
      end
      if (p > 64'd2147483647) begin
         sat = 1; return 64'sd2147483647;
      end
      return p;
   endfunction

   task automatic predict_fix(input longint lon_in, input longint lat_in,
                              input longint head_in, output rsp_type res);
      longint lon, lat, olon, olat, h, s, c, qz, qw, nc, e, n_off;
      logic [63:0] a, b, ac, bs, r, t, u, nr, mr;
      bit sat;
      sat = 0;
      a = axis_a;
      b = axis_b;
      lon = to_rad(lon_in, DEG7_TO_Q28, 32);
      lat = to_rad(lat_in, DEG7_TO_Q28, 32);
      olon = to_rad(longint'(org_lon), DEG7_TO_Q28, 32);
      olat = to_rad(longint'(org_lat), DEG7_TO_Q28, 32);
      h = to_rad(head_in, DEG5_TO_Q28, 24);
      rotate(lat * 4, s, c);
      ac = (a * mag64(c)) >> 32;
      bs = (b * mag64(s)) >> 32;
      r = int_sqrt(ac * ac + bs * bs);
      t = axis_ratio(a >> 2, r);
      u = axis_ratio(b >> 2, r);
      nr = (a * t) >> 30;
      mr = (((nr * u) >> 30) * u) >> 30;
      nc = (nr * mag64(c)) >> 30;
      if (c < 0) nc = -nc;
      e = offset(lon - olon, nc, sat);
      n_off = offset(lat - olat, mr, sat);
      if (h < 0) h += HEAD_WRAP;
      if (h > HEAD_WRAP) h -= HEAD_WRAP;
      if (h < 0) h = 0;
      if (h > HEAD_WRAP) h = HEAD_WRAP;
      rotate(h * 2, qz, qw);
      res.east_mm = e[31:0];
      res.north_mm = n_off[31:0];
      res.saturated = sat;
      res.heading_angle = h[30:0];
      res.quat_z = qz[31:0];
      res.quat_w = qw[31:0];
   endtask

   assign pending_fixes = fix_results.size();

   always @(posedge clock) begin
      rsp_type exp_r, got;
      if (reset) begin
         org_lat <= ORIGIN_LAT_RESET;
         org_lon <= ORIGIN_LON_RESET;
         axis_a <= SEMI_MAJOR_RESET;
         axis_b <= SEMI_MINOR_RESET;
         fix_results.delete();
         fail_count <= 0;
         checked_fixes <= 0;
         sat_fixes <= 0;
         mism = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_LAT: org_lat <= csr_wdata[30:0];
               CSR_ORIGIN_LON: org_lon <= csr_wdata[31:0];
               CSR_SEMI_MAJOR: axis_a <= csr_wdata;
               CSR_SEMI_MINOR: axis_b <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (push && !full) begin
            predict_fix(req_lon_raw, req_lat_raw, req_heading_raw, exp_r);
            fix_results = {fix_results, exp_r};
         end
         if (pop && !empty) begin
            got = '{rsp_east_mm, rsp_north_mm, rsp_saturated, rsp_heading_angle,
                    rsp_quat_z, rsp_quat_w};
            if (fix_results.size() == 0) begin
               mism++;
               if (mism <= 10) $display("unexpected result transaction %p", got);
            end else begin
               exp_r = fix_results.pop_front();
               if (exp_r.saturated) sat_fixes <= sat_fixes + 1;
               if (got !== exp_r) begin
                  mism++;
                  if (mism <= 10)
                     $display("mismatch: expected %p actual %p", exp_r, got);
               end
            end
            checked_fixes <= checked_fixes + 1;
         end
         fail_count <= mism;
      end
   end

endmodule

// ----- bench/tb_top.sv -----
// Top of the bench: clock, reset, fix stimulus, register phases and verdict.
module tb_top;
   import g2enu_pkg::*;

   logic clock, reset, push, pop, csr_we;
   logic full, empty, rsp_saturated;
   logic signed [31:0] req_lon_raw, rsp_east_mm, rsp_north_mm, rsp_quat_z, rsp_quat_w;
   logic signed [30:0] req_lat_raw;
   logic signed [27:0] req_heading_raw;
   logic [30:0] rsp_heading_angle;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count, pending_fixes, checked_fixes, sat_fixes;
   int hold_off;

   geodetic_to_local_enu DUT (.*);

   enu_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random pop gaps, one long hold-off to fill the queues
   initial begin
      int gap;
      bit stalled;
      pop = 0;
      stalled = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0 && !stalled) begin
            pop <= 0;
            repeat (hold_off) @(posedge clock);
            stalled = 1;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [32:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic send_fix(input logic [31:0] lon, input logic [30:0] lat,
                           input logic [27:0] head, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_lon_raw <= lon;
      req_lat_raw <= lat;
      req_heading_raw <= head;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic drain;
      push <= 0;
      @(posedge clock);
      while (pending_fixes != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_lon();
      return $urandom_range(0, 7) == 0 ? $urandom() :
             32'(int'($urandom_range(0, 3600000000)) - 1800000000);
   endfunction

   function automatic logic [30:0] rand_lat();
      return $urandom_range(0, 7) == 0 ? 31'($urandom()) :
             31'(int'($urandom_range(0, 1800000000)) - 900000000);
   endfunction

   function automatic logic [27:0] rand_head();
      return $urandom_range(0, 7) == 0 ? 28'($urandom()) :
             28'(int'($urandom_range(0, 108000000)) - 36000000);
   endfunction

   // origin near the fix keeps offsets in range; sometimes far away to hit saturation
   task automatic near_fix(input bit burst);
      int olat, olon;
      olat = int'(ORIGIN_LAT_RESET);
      olon = int'(ORIGIN_LON_RESET);
      if ($urandom_range(0, 4) == 0)
         send_fix(rand_lon(), rand_lat(), rand_head(), burst);
      else
         send_fix(32'(olon + int'($urandom_range(0, 20000000)) - 10000000),
                  31'(olat + int'($urandom_range(0, 20000000)) - 10000000),
                  rand_head(), burst);
   endtask

   initial begin
      logic [32:0] axes [4] = '{33'd6000000000, 33'd7000000000, 33'd6378137000,
                                33'd6356752314};
      reset = 1;
      push = 0;
      csr_we = 0;
      csr_index = CSR_ORIGIN_LAT;
      csr_wdata = 0;
      req_lon_raw = 0;
      req_lat_raw = 0;
      req_heading_raw = 0;
      hold_off = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed fixes at reset origin
      send_fix(32'sd1270748800, 31'sd375403580, 28'sd0, 0);
      send_fix(32'sd1800000000, 31'sd900000000, 28'sd72000000, 0);
      send_fix(-32'sd1800000000, -31'sd900000000, -28'sd36000000, 0);
      send_fix(32'h7FFFFFFF, 31'h3FFFFFFF, 28'h7FFFFFF, 0);
      send_fix(32'h80000000, 31'h40000000, 28'h8000000, 0);
      send_fix(32'hFFFFFFFF, 31'h7FFFFFFF, 28'hFFFFFFF, 0);
      send_fix(32'sd0, 31'sd0, 28'sd36000000, 0);
      send_fix(32'sd1270748801, 31'sd375403581, 28'sd18000000, 0);
      send_fix(32'sd0, 31'sd1200000000, 28'sd9000000, 0);
      send_fix(32'sd0, -31'sd1200000000, 28'sd27000000, 0);
      send_fix(32'sd1270748800, 31'sd899999999, -28'sd1, 0);
      send_fix(32'sd1270758800, 31'sd375413580, 28'sd71999999, 0);
      drain();

      // register phases: extremes first, then random
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_ORIGIN_LAT, ph == 0 ? 33'(31'h40000000) : ph == 1 ?
                   33'(31'h3FFFFFFF) : 33'(rand_lat()));
         csr_write(CSR_ORIGIN_LON, ph == 0 ? 33'(32'h80000000) : ph == 1 ?
                   33'(32'h7FFFFFFF) : 33'(rand_lon()));
         csr_write(CSR_SEMI_MAJOR, ph < 4 ? axes[ph] : 33'($urandom_range(0, 1000000000))
                   + 33'd6000000000);
         csr_write(CSR_SEMI_MINOR, ph < 4 ? axes[3 - ph] : ph == 7 ? 33'h1FFFFFFFF :
                   33'($urandom_range(0, 1000000000)) + 33'd6000000000);
         for (int k = 0; k < 40; k++)
            send_fix(rand_lon(), rand_lat(), rand_head(), $urandom_range(0, 3) == 0);
         drain();
      end

      // back to reset values, mostly nearby fixes; long receiver stall in the middle
      csr_write(CSR_ORIGIN_LAT, 33'(ORIGIN_LAT_RESET));
      csr_write(CSR_ORIGIN_LON, 33'(ORIGIN_LON_RESET));
      csr_write(CSR_SEMI_MAJOR, SEMI_MAJOR_RESET);
      csr_write(CSR_SEMI_MINOR, SEMI_MINOR_RESET);
      for (int k = 0; k < 380; k++) begin
         if (k == 100) hold_off = 1500;
         near_fix(k >= 100 && k < 130);
      end
      drain();

      $display("Checked %0d fixes over several origin/axis settings, %0d saturated.",
               checked_fixes, sat_fixes);
      if (fail_count == 0 && pending_fixes == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
